[design/coancestry_table_builder_macros.svh]
// Assertion macros for the checker file of the coancestry table builder.
`ifndef COANCESTRY_TABLE_BUILDER_MACROS_SVH
`define COANCESTRY_TABLE_BUILDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ctb_pkg.sv]
`default_nettype none

package ctb_pkg;

  // Default configuration of the table.
  localparam int unsigned MAX_INDIVIDUALS_DEF = 256;
  localparam int unsigned FRACTION_BITS_DEF   = 16;

  // Fixed field widths of the command and result items.
  localparam int unsigned IDX_W = 8;
  localparam int unsigned COA_W = 17;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_PARENT = 2'd2,
    STAT_RANGE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH,
    S_QUERY
  } state_e;

  typedef struct packed {
    cmd_e             command;
    logic             is_founder;
    logic [IDX_W-1:0] first_parent;
    logic [IDX_W-1:0] second_parent;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] column_index;
  } cmd_t;

  typedef struct packed {
    status_e          status;
    logic [COA_W-1:0] coancestry;
    logic [IDX_W-1:0] added_index;
  } res_t;

endpackage

`default_nettype wire

[design/ctb_store.sv]
`default_nettype none

module ctb_store #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 17
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_a_i,
  input  wire logic [AW-1:0] raddr_b_i,
  output logic      [DW-1:0] rdata_a_o,
  output logic      [DW-1:0] rdata_b_o
);

  // Contents are undefined until written; nothing clears them.
  logic [DW-1:0] mem [(2**AW)];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

[design/coancestry_table_builder.sv]
// An add that is refused, or one to a full table, answers in the cycle after start.
// An add that is taken walks over the i earlier individuals, i being the index it receives,
// one per cycle on the store's two read ports, and then passes through S_FLUSH to answer.
// A query presents its address while idle, reads the store once and answers from S_QUERY.
// For a taken add and a query, busy is high until the answer. The next item can be taken in
// the answer cycle, not before; the receiver cannot stall. Reset clears the count and control, not the store.
`default_nettype none

module coancestry_table_builder #(
  parameter int unsigned MAX_INDIVIDUALS = ctb_pkg::MAX_INDIVIDUALS_DEF,
  parameter int unsigned FRACTION_BITS   = ctb_pkg::FRACTION_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire ctb_pkg::cmd_t cmd_i,
  output logic               done_o,
  output ctb_pkg::res_t      res_o
);

  import ctb_pkg::*;

  // Index width addresses one individual; the count must also hold the full value.
  localparam int unsigned IW   = (MAX_INDIVIDUALS > 1) ? $clog2(MAX_INDIVIDUALS) : 1;
  localparam int unsigned CW   = $clog2(MAX_INDIVIDUALS + 1);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned AW   = 2 * IW;
  // Coefficients are Q1.FRACTION_BITS.
  localparam int unsigned VW   = FRACTION_BITS + 1;
  localparam logic [VW-1:0] VALUE_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  // The table is symmetric, so only the lower triangle is kept: entry (a, b) lives at
  // row max(a, b), column min(a, b). Rows are laid out by concatenation.
  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] a, input logic [IW-1:0] b);
    if (a >= b) begin
      return {a, b};
    end else begin
      return {b, a};
    end
  endfunction

  state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] idx_q, idx_d;       // index of the individual being added
  logic [IW-1:0] par_a_q, par_a_d;
  logic [IW-1:0] par_b_q, par_b_d;
  logic          founder_q, founder_d;
  logic [IW-1:0] col_q, col_d;       // column whose parent entries are being read
  logic          rd_vld_q, rd_vld_d; // read data of a walk step arrives this cycle
  logic [IW-1:0] rd_col_q, rd_col_d;
  status_e       qstat_q, qstat_d;
  logic          done_q, done_d;
  res_t          res_q, res_d;

  logic          accept;
  logic          add_full;
  logic          add_bad_par;
  logic          add_ok;
  logic          query_ok;
  logic [IW-1:0] new_idx;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [VW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr_a;
  logic [AW-1:0] mem_raddr_b;
  logic [VW-1:0] mem_rdata_a;
  logic [VW-1:0] mem_rdata_b;
  logic [VW-1:0] blend;

  assign accept  = start && (state_q == S_IDLE);
  assign busy    = (state_q != S_IDLE);
  assign new_idx = IW'(count_q);

  // Decoding of the command item against the current count.
  assign add_full    = (count_q == CW'(MAX_INDIVIDUALS));
  assign add_bad_par = !cmd_i.is_founder &&
                       ((CMPW'(cmd_i.first_parent) >= CMPW'(count_q)) ||
                        (CMPW'(cmd_i.second_parent) >= CMPW'(count_q)));
  assign add_ok      = accept && (cmd_i.command == CMD_ADD) && !add_full && !add_bad_par;
  assign query_ok    = (CMPW'(cmd_i.row_index) < CMPW'(count_q)) &&
                       (CMPW'(cmd_i.column_index) < CMPW'(count_q));

  // Each halving truncates on its own before the two halves are summed.
  assign blend = founder_q ? '0 : ((mem_rdata_a >> 1) + (mem_rdata_b >> 1));

  ctb_store #(
    .AW (AW),
    .DW (VW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_i.command == CMD_QUERY) begin
            state_d = S_QUERY;
          end else if (add_ok) begin
            // The very first individual has no earlier ones to walk.
            state_d = (count_q == '0) ? S_FLUSH : S_WALK;
          end
        end
      end
      S_WALK: begin
        if (col_q == idx_q - IW'(1)) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: state_d = S_IDLE;
      S_QUERY: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control and result formation.
  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    par_a_d     = par_a_q;
    par_b_d     = par_b_q;
    founder_d   = founder_q;
    col_d       = col_q;
    rd_vld_d    = 1'b0;
    rd_col_d    = col_q;
    qstat_d     = qstat_q;
    done_d      = 1'b0;
    res_d       = res_q;
    mem_raddr_a = cell_addr(par_a_q, col_q);
    mem_raddr_b = cell_addr(par_b_q, col_q);
    // A walk step writes the entry whose parent data came back this cycle.
    mem_we      = rd_vld_q;
    mem_waddr   = cell_addr(idx_q, rd_col_q);
    mem_wdata   = blend;

    case (state_q)
      S_IDLE: begin
        // A query uses the idle cycle to present its read address.
        mem_raddr_a = cell_addr(IW'(cmd_i.row_index), IW'(cmd_i.column_index));
        if (accept) begin
          if (cmd_i.command == CMD_QUERY) begin
            qstat_d = query_ok ? STAT_OK : STAT_RANGE;
          end else if (add_full || add_bad_par) begin
            done_d            = 1'b1;
            res_d.status      = add_full ? STAT_FULL : STAT_PARENT;
            res_d.coancestry  = '0;
            res_d.added_index = '0;
          end else begin
            // Diagonal entry is one; no walk write can be pending in this state.
            mem_we    = 1'b1;
            mem_waddr = cell_addr(new_idx, new_idx);
            mem_wdata = VALUE_ONE;
            count_d   = count_q + CW'(1);
            idx_d     = new_idx;
            par_a_d   = IW'(cmd_i.first_parent);
            par_b_d   = IW'(cmd_i.second_parent);
            founder_d = cmd_i.is_founder;
            col_d     = '0;
          end
        end
      end
      S_WALK: begin
        rd_vld_d = 1'b1;
        rd_col_d = col_q;
        col_d    = col_q + IW'(1);
      end
      S_FLUSH: begin
        done_d            = 1'b1;
        res_d.status      = STAT_OK;
        res_d.coancestry  = '0;
        res_d.added_index = IDX_W'(idx_q);
      end
      S_QUERY: begin
        done_d            = 1'b1;
        res_d.status      = qstat_q;
        res_d.coancestry  = (qstat_q == STAT_OK) ? COA_W'(mem_rdata_a) : '0;
        res_d.added_index = '0;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    par_a_q   <= par_a_d;
    par_b_q   <= par_b_d;
    founder_q <= founder_d;
    col_q     <= col_d;
    rd_col_q  <= rd_col_d;
    qstat_q   <= qstat_d;
    res_q     <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

[design/ctb_checker.sv]
`default_nettype none
`include "coancestry_table_builder_macros.svh"

module ctb_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire ctb_pkg::cmd_t cmd_i,
  input wire logic          done_o,
  input wire ctb_pkg::res_t res_o
);

  import ctb_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // A result is only ever shown once the block is free again.
  `CTB_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy, "result while busy")

  // A refused item carries neither a coefficient nor an index.
  `CTB_ASSERT_NOW(a_err_zero, clk_i, rst_ni, done_o && (res_o.status != STAT_OK),
    (res_o.coancestry == '0) && (res_o.added_index == '0), "error result not zeroed")

  // An add either answers at once or keeps the block busy.
  `CTB_ASSERT_NEXT(a_add_resp, clk_i, rst_ni, accept && (cmd_i.command == CMD_ADD),
    busy || done_o, "add item lost")

  // A query that is taken must be answered.
  `CTB_ASSERT_NEXT(a_query_lat, clk_i, rst_ni, accept && (cmd_i.command == CMD_QUERY),
    ##1 done_o, "query answer missing")

endmodule

bind coancestry_table_builder ctb_checker u_ctb_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .cmd_i  (cmd_i),
  .done_o (done_o),
  .res_o  (res_o)
);

`default_nettype wire
